### hw/rtl/pfe_pkg.sv
// Shared types and constants of the postfix expression evaluator.
// Standalone package; used by the top level and its checker.
package pfe_pkg;

	localparam int SYM_W    = 8;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 3;

	localparam int DEF_STACK_DEPTH   = 32;
	localparam int DEF_FRACTION_BITS = 16;

	// status codes, first error wins
	localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DIVZERO = 3'd1;
	localparam logic [STATUS_W-1:0] ST_UNDER   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_OVER    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_SAT     = 3'd4;

	// ASCII codes of interest
	localparam logic [SYM_W-1:0] CH_ZERO  = 8'd48;
	localparam logic [SYM_W-1:0] CH_NINE  = 8'd57;
	localparam logic [SYM_W-1:0] CH_PLUS  = 8'd43;
	localparam logic [SYM_W-1:0] CH_MINUS = 8'd45;
	localparam logic [SYM_W-1:0] CH_MUL   = 8'd42;
	localparam logic [SYM_W-1:0] CH_DIV   = 8'd47;

	function automatic logic is_digit(input logic [SYM_W-1:0] sym);
		return (sym >= CH_ZERO) && (sym <= CH_NINE);
	endfunction

	function automatic logic is_operator(input logic [SYM_W-1:0] sym);
		return (sym == CH_PLUS) || (sym == CH_MINUS) || (sym == CH_MUL) || (sym == CH_DIV);
	endfunction

endpackage

### hw/rtl/postfix_expression_evaluator.sv
// Postfix expression evaluator, signed fixed point, one ASCII character per transaction.
// Digits and ignored characters need no further state; + and - pass S_LOAD and S_FIX2;
// * takes 32 shift-add steps, / one quotient bit per cycle; a character with tlast adds S_EMIT.
// Rate is set by the shared add/subtract unit that iterates the multiply and divide.
// Reset (arst_n low, asynchronous): stack holds a single zero, status clear, output empty.
// Depends on pfe_pkg.
module postfix_expression_evaluator #(
	parameter int STACK_DEPTH   = pfe_pkg::DEF_STACK_DEPTH,
	parameter int FRACTION_BITS = pfe_pkg::DEF_FRACTION_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input characters
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [pfe_pkg::SYM_W-1:0]     s_axis_tdata,  // [7:0] symbol
	input  logic                          s_axis_tlast,  // last character of the expression
	// results
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [pfe_pkg::VALUE_W-1:0]   m_axis_tdata,  // [31:0] value, signed fixed point
	output logic [pfe_pkg::STATUS_W-1:0]  m_axis_tuser   // [2:0] status
);
	import pfe_pkg::*;

	localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW  = $clog2(STACK_DEPTH + 1);
	localparam int LW  = VALUE_W + FRACTION_BITS;   // dividend / quotient width
	localparam int IW  = $clog2(LW + 1);
	localparam int HW  = VALUE_W + 1;               // accumulator / remainder width
	localparam int RW  = 2 * VALUE_W + 1;           // signed wide result

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LOAD = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_FIX1 = 3'd4;
	localparam logic [2:0] S_FIX2 = 3'd5;
	localparam logic [2:0] S_POP  = 3'd6;
	localparam logic [2:0] S_EMIT = 3'd7;

	localparam logic [CW-1:0] CNT_ONE = CW'(1);
	localparam logic [CW-1:0] CNT_TWO = CW'(2);
	localparam logic [CW-1:0] CNT_TRE = CW'(3);
	localparam logic [CW-1:0] CNT_MAX = CW'(STACK_DEPTH);

	logic [2:0]          state_q;
	logic [CW-1:0]       count_q;      // entries on the stack, top included
	logic [VALUE_W-1:0]  top_q;        // top entry lives here, rest in stack_mem
	logic [STATUS_W-1:0] err_q;
	logic [SYM_W-1:0]    op_q;
	logic                last_q;

	// shared unit operands and iteration state
	logic [HW-1:0]       hi_q;         // product high half or partial remainder
	logic [LW-1:0]       lo_q;         // multiplier / product low half or dividend / quotient
	logic [VALUE_W-1:0]  b_q;          // |t|
	logic                neg_q;
	logic                shift_q;      // apply the fraction shift after multiply
	logic [IW-1:0]       iter_q;
	logic signed [RW-1:0] res_q;

	logic                m_valid_q;
	logic [VALUE_W-1:0]  m_data_q;
	logic [STATUS_W-1:0] m_user_q;

	// stack memory below the top entry
	logic [VALUE_W-1:0]  stack_mem [STACK_DEPTH];
	logic [VALUE_W-1:0]  rd_q;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [AW-1:0]       mem_raddr;

	logic                in_acc;
	logic                out_free;
	logic [VALUE_W-1:0]  digit_val;
	logic [VALUE_W-1:0]  abs_s;
	logic [VALUE_W-1:0]  abs_t;
	logic [HW:0]         alu_x;
	logic [HW:0]         alu_sum;
	logic [HW-1:0]       mul_hi_n;
	logic                div_ge;
	logic [2*VALUE_W-1:0] mag;
	logic signed [RW-1:0] shifted;
	logic                sat_hi;
	logic                sat_lo;
	logic [VALUE_W-1:0]  clamped;
	logic signed [HW-1:0] addsub;

	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	always_comb begin
		digit_val = VALUE_W'(s_axis_tdata - CH_ZERO) << FRACTION_BITS;
		// a digit push spills the old top into memory
		mem_we    = in_acc && is_digit(s_axis_tdata) && (count_q < CNT_MAX) && (count_q != '0);
		mem_waddr = AW'(count_q - CNT_ONE);
		// second entry on accept, new top after a divide by zero
		mem_raddr = (state_q == S_IDLE) ? AW'(count_q - CNT_TWO) : AW'(count_q - CNT_TRE);
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[mem_waddr] <= top_q;
		end
		rd_q <= stack_mem[mem_raddr];
	end

	// operand magnitudes, s from memory, t from the top register
	always_comb begin
		abs_s  = rd_q[VALUE_W-1] ? (VALUE_W'(0) - rd_q) : rd_q;
		abs_t  = top_q[VALUE_W-1] ? (VALUE_W'(0) - top_q) : top_q;
		addsub = (op_q == CH_MINUS) ?
			(HW'(signed'(rd_q)) - HW'(signed'(top_q))) :
			(HW'(signed'(rd_q)) + HW'(signed'(top_q)));
	end

	// shared add/subtract unit: accumulate for multiply, trial subtract for divide
	always_comb begin
		if (state_q == S_MUL) begin
			alu_x   = {1'b0, hi_q};
			alu_sum = alu_x + (HW+1)'(b_q);
		end else begin
			alu_x   = {1'b0, hi_q[HW-2:0], lo_q[LW-1]};
			alu_sum = alu_x - (HW+1)'(b_q);
		end
		mul_hi_n = lo_q[0] ? alu_sum[HW-1:0] : hi_q;
		div_ge   = !alu_sum[HW];
	end

	// result magnitude, then shift and clamp
	always_comb begin
		if (shift_q) begin
			mag = {hi_q[VALUE_W-1:0], lo_q[LW-1 -: VALUE_W]};
		end else begin
			mag = (2*VALUE_W)'(lo_q);
		end
		shifted = shift_q ? (res_q >>> FRACTION_BITS) : res_q;
		sat_hi  = !shifted[RW-1] && (shifted[RW-2:VALUE_W-1] != '0);
		sat_lo  = shifted[RW-1] && (shifted[RW-2:VALUE_W-1] != '1);
		priority if (sat_hi) begin
			clamped = {1'b0, {(VALUE_W-1){1'b1}}};
		end else if (sat_lo) begin
			clamped = {1'b1, {(VALUE_W-1){1'b0}}};
		end else begin
			clamped = shifted[VALUE_W-1:0];
		end
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_LOAD: begin
				hi_q    <= '0;
				b_q     <= abs_t;
				neg_q   <= rd_q[VALUE_W-1] ^ top_q[VALUE_W-1];
				shift_q <= (op_q == CH_MUL);
				res_q   <= RW'(addsub);
				if (op_q == CH_MUL) begin
					lo_q   <= LW'(abs_s);
					iter_q <= IW'(VALUE_W);
				end else begin
					lo_q   <= LW'(abs_s) << FRACTION_BITS;
					iter_q <= IW'(LW);
				end
			end
			S_MUL: begin
				hi_q   <= {1'b0, mul_hi_n[HW-1:1]};
				lo_q   <= {mul_hi_n[0], lo_q[LW-1:1]};
				iter_q <= iter_q - IW'(1);
			end
			S_DIV: begin
				hi_q   <= div_ge ? alu_sum[HW-1:0] : alu_x[HW-1:0];
				lo_q   <= {lo_q[LW-2:0], div_ge};
				iter_q <= iter_q - IW'(1);
			end
			S_FIX1: begin
				res_q <= neg_q ? (RW'(0) - RW'(mag)) : RW'(mag);
			end
			default: begin
			end
		endcase
	end

	// sequencer and stack control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= CNT_ONE;
			top_q     <= '0;
			err_q     <= ST_OK;
			op_q      <= '0;
			last_q    <= 1'b0;
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
			m_user_q  <= ST_OK;
		end else begin
			// the emit state reloads the output register itself
			if (m_valid_q && m_axis_tready && state_q != S_EMIT) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						op_q   <= s_axis_tdata;
						last_q <= s_axis_tlast;
						priority if (is_digit(s_axis_tdata)) begin
							if (count_q < CNT_MAX) begin
								top_q   <= digit_val;
								count_q <= count_q + CNT_ONE;
							end else if (err_q == ST_OK) begin
								err_q <= ST_OVER;
							end
							state_q <= s_axis_tlast ? S_EMIT : S_IDLE;
						end else if (is_operator(s_axis_tdata)) begin
							if (count_q < CNT_TWO) begin
								if (err_q == ST_OK) begin
									err_q <= ST_UNDER;
								end
								state_q <= s_axis_tlast ? S_EMIT : S_IDLE;
							end else begin
								state_q <= S_LOAD;
							end
						end else begin
							state_q <= s_axis_tlast ? S_EMIT : S_IDLE;
						end
					end
				end
				S_LOAD: begin
					priority if (op_q == CH_PLUS || op_q == CH_MINUS) begin
						count_q <= count_q - CNT_ONE;
						state_q <= S_FIX2;
					end else if (op_q == CH_MUL) begin
						count_q <= count_q - CNT_ONE;
						state_q <= S_MUL;
					end else if (top_q == '0) begin
						// divide by zero: both popped, nothing pushed
						count_q <= count_q - CNT_TWO;
						if (err_q == ST_OK) begin
							err_q <= ST_DIVZERO;
						end
						if (count_q > CNT_TWO) begin
							state_q <= S_POP;
						end else begin
							state_q <= last_q ? S_EMIT : S_IDLE;
						end
					end else begin
						count_q <= count_q - CNT_ONE;
						state_q <= S_DIV;
					end
				end
				S_MUL, S_DIV: begin
					if (iter_q == IW'(1)) begin
						state_q <= S_FIX1;
					end
				end
				S_FIX1: begin
					state_q <= S_FIX2;
				end
				S_FIX2: begin
					top_q <= clamped;
					if ((sat_hi || sat_lo) && err_q == ST_OK) begin
						err_q <= ST_SAT;
					end
					state_q <= last_q ? S_EMIT : S_IDLE;
				end
				S_POP: begin
					top_q   <= rd_q;
					state_q <= last_q ? S_EMIT : S_IDLE;
				end
				S_EMIT: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						if (count_q == '0) begin
							m_data_q <= '0;
							m_user_q <= (err_q == ST_OK) ? ST_UNDER : err_q;
						end else begin
							m_data_q <= top_q;
							m_user_q <= err_q;
						end
						count_q <= CNT_ONE;
						top_q   <= '0;
						err_q   <= ST_OK;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### hw/rtl/pfe_checker.sv
// Port-level checks for the postfix expression evaluator, bound to the top level.
// Depends on pfe_pkg and postfix_expression_evaluator.
module pfe_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic [pfe_pkg::SYM_W-1:0]     s_axis_tdata,
	input logic                          s_axis_tlast,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [pfe_pkg::VALUE_W-1:0]   m_axis_tdata,
	input logic [pfe_pkg::STATUS_W-1:0]  m_axis_tuser
);
	import pfe_pkg::*;

	logic in_acc;
	assign in_acc = s_axis_tvalid && s_axis_tready;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// status is always a defined code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser <= ST_SAT))
		else $error("undefined status code");

	// digits and ignored characters without tlast never stall the input
	a_fast_path: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !s_axis_tlast && !is_operator(s_axis_tdata) |=> s_axis_tready)
		else $error("non-operator character stalled the input");

	// the end of an expression blocks input until the result is out
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && s_axis_tlast |=> !s_axis_tready)
		else $error("input taken before the result was issued");

endmodule

bind postfix_expression_evaluator pfe_checker u_pfe_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

### test/postfix_expression_evaluator_tb.sv
// Self-checking testbench for postfix_expression_evaluator: directed and random expressions,
// predicted in fixed point by a local stack calculator and checked on every result transaction.
// Depends on pfe_pkg and the postfix_expression_evaluator top level.
`timescale 1ns / 100ps

module postfix_expression_evaluator_tb;
	import pfe_pkg::*;

	localparam int DEPTH          = DEF_STACK_DEPTH;
	localparam int FRAC           = DEF_FRACTION_BITS;
	localparam int RANDOM_TOKENS  = 1600;   // digits and operators in the random part
	localparam int DRAIN_CYCLES   = 80;     // longest op is a divide
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int MAX_PRINTED    = 50;

	localparam longint VAL_MAX = 64'sd2147483647;
	localparam longint VAL_MIN = -64'sd2147483648;

	typedef struct packed {
		logic [SYM_W-1:0] sym;
		logic             last;
	} char_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [STATUS_W-1:0]       status;
	} result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [SYM_W-1:0]    s_axis_tdata  = '0;   // [7:0] symbol
	logic                s_axis_tlast  = 1'b0; // last character of the expression
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [VALUE_W-1:0]  m_axis_tdata;         // [31:0] value, signed Q16.16
	logic [STATUS_W-1:0] m_axis_tuser;         // [2:0] status

	postfix_expression_evaluator #(
		.STACK_DEPTH  (DEPTH),
		.FRACTION_BITS(FRAC)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always #2 clk = ~clk;

	// Stimulus and scoreboard storage
	char_t   pending_chars[$];
	result_t expected_results[$];

	int token_count    = 0;
	int error_count    = 0;
	int chars_accepted = 0;
	int results_seen   = 0;
	int expressions    = 0;
	int status_tally[5];

	// Calculator state mirrored from the block: value stack, depth, first error
	logic signed [VALUE_W-1:0] calc_stack[DEPTH];
	int unsigned               calc_depth;
	logic [STATUS_W-1:0]       calc_status;

	function automatic logic sym_is_digit(logic [SYM_W-1:0] sym);
		return sym >= CH_ZERO && sym <= CH_NINE;
	endfunction

	function automatic logic sym_is_op(logic [SYM_W-1:0] sym);
		return sym == CH_PLUS || sym == CH_MINUS || sym == CH_MUL || sym == CH_DIV;
	endfunction

	function automatic void clear_calculator();
		foreach (calc_stack[i])
			calc_stack[i] = '0;
		calc_depth  = 1;
		calc_status = ST_OK;
	endfunction

	// Only the first error of an expression is kept
	function automatic void note_error(logic [STATUS_W-1:0] code);
		if (calc_status == ST_OK)
			calc_status = code;
	endfunction

	function automatic void push_value(logic signed [VALUE_W-1:0] v);
		if (calc_depth >= DEPTH) begin
			note_error(ST_OVER);
		end else begin
			calc_stack[calc_depth] = v;
			calc_depth++;
		end
	endfunction

	// Applies one accepted character; on tlast queues the expected result and restarts.
	function automatic void evaluate_symbol(logic [SYM_W-1:0] sym, logic last);
		longint  top_v;
		longint  second_v;
		longint  outcome;
		logic    produce;
		result_t r;
		produce = 1'b1;
		if (sym_is_digit(sym)) begin
			outcome = (longint'(sym) - longint'(CH_ZERO)) <<< FRAC;
			push_value(outcome[VALUE_W-1:0]);
		end else if (sym_is_op(sym)) begin
			if (calc_depth < 2) begin
				// too few operands: stack left as is
				note_error(ST_UNDER);
			end else begin
				top_v    = calc_stack[calc_depth-1];
				second_v = calc_stack[calc_depth-2];
				calc_depth -= 2;
				outcome = 0;
				case (sym)
					CH_PLUS:  outcome = second_v + top_v;
					CH_MINUS: outcome = second_v - top_v;
					CH_MUL:   outcome = (second_v * top_v) >>> FRAC;  // floors
					default: begin
						if (top_v == 0) begin
							// both operands gone, nothing pushed
							note_error(ST_DIVZERO);
							produce = 1'b0;
						end else begin
							outcome = (second_v <<< FRAC) / top_v;  // truncates toward zero
						end
					end
				endcase
				if (produce) begin
					if (outcome > VAL_MAX) begin
						note_error(ST_SAT);
						outcome = VAL_MAX;
					end else if (outcome < VAL_MIN) begin
						note_error(ST_SAT);
						outcome = VAL_MIN;
					end
					push_value(outcome[VALUE_W-1:0]);
				end
			end
		end
		if (last) begin
			if (calc_depth == 0) begin
				note_error(ST_UNDER);
				r.value = '0;
			end else begin
				r.value = calc_stack[calc_depth-1];
			end
			r.status = calc_status;
			expected_results.push_back(r);
			status_tally[calc_status]++;
			expressions++;
			clear_calculator();
		end
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= MAX_PRINTED)
			$display("[%0t] MISMATCH: %s", $time, msg);
	endtask

	// ---------------------------------------------------------------- stimulus builders

	function automatic void queue_char(logic [SYM_W-1:0] sym, logic last);
		char_t c;
		c.sym  = sym;
		c.last = last;
		pending_chars.push_back(c);
		if (sym_is_digit(sym) || sym_is_op(sym))
			token_count++;
	endfunction

	function automatic logic [SYM_W-1:0] random_digit(int lo, int hi);
		return CH_ZERO + SYM_W'($urandom_range(lo, hi));
	endfunction

	function automatic logic [SYM_W-1:0] random_operator();
		case ($urandom_range(0, 3))
			0:       return CH_PLUS;
			1:       return CH_MINUS;
			2:       return CH_MUL;
			default: return CH_DIV;
		endcase
	endfunction

	// A character the block ignores
	function automatic logic [SYM_W-1:0] filler_symbol();
		logic [SYM_W-1:0] sym;
		do
			sym = SYM_W'($urandom_range(0, 255));
		while (sym_is_digit(sym) || sym_is_op(sym));
		return sym;
	endfunction

	function automatic void queue_text(string s);
		for (int i = 0; i < s.len(); i++)
			queue_char(s[i], i == s.len() - 1);
	endfunction

	// Closing character: digit, operator or any byte at all
	function automatic void queue_final_char();
		case ($urandom_range(0, 3))
			0:       queue_char(random_digit(0, 9), 1'b1);
			3:       queue_char(SYM_W'($urandom_range(0, 255)), 1'b1);
			default: queue_char(random_operator(), 1'b1);
		endcase
	endfunction

	function automatic void queue_random_expression();
		int kind;
		int len;
		int depth_est;
		kind = $urandom_range(0, 19);
		depth_est = 1;  // the starting zero
		if (kind <= 12) begin
			// mostly well formed, some ignored characters mixed in
			len = $urandom_range(1, 12);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 9) == 0)
					queue_char(filler_symbol(), 1'b0);
				if (depth_est >= 2 && $urandom_range(0, 2) != 0) begin
					queue_char(random_operator(), 1'b0);
					depth_est--;
				end else begin
					queue_char(random_digit(0, 9), 1'b0);
					depth_est++;
				end
			end
			while (depth_est > 2 && $urandom_range(0, 3) != 0) begin
				queue_char(random_operator(), 1'b0);
				depth_est--;
			end
		end else if (kind <= 14) begin
			// fill the stack close to or past its depth
			len = $urandom_range(28, 36);
			for (int i = 0; i < len; i++)
				queue_char(random_digit(0, 9), 1'b0);
			len = $urandom_range(0, 5);
			for (int i = 0; i < len; i++)
				queue_char(random_operator(), 1'b0);
		end else if (kind <= 16) begin
			// multiply chain that tends to clip, negated half the time
			if ($urandom_range(0, 1)) begin
				queue_char(CH_ZERO, 1'b0);
				queue_char(random_digit(5, 9), 1'b0);
				queue_char(CH_MINUS, 1'b0);
			end else begin
				queue_char(random_digit(5, 9), 1'b0);
			end
			len = $urandom_range(3, 7);
			for (int i = 0; i < len; i++) begin
				queue_char(random_digit(2, 9), 1'b0);
				queue_char(CH_MUL, 1'b0);
			end
			if ($urandom_range(0, 1))
				queue_char(random_digit(0, 9), 1'b0);
		end else begin
			// broken: operators heavy, random bytes
			len = $urandom_range(0, 8);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 1))
					queue_char(random_operator(), 1'b0);
				else
					queue_char(SYM_W'($urandom_range(0, 255)), 1'b0);
			end
		end
		queue_final_char();
	endfunction

	// ---------------------------------------------------------------- input driver

	int burst_left = 1;
	int gap_left   = 0;

	always @(posedge clk) begin : char_driver
		char_t next_ch;
		logic  take;
		if (arst_n) begin
			take = s_axis_tvalid && s_axis_tready;
			if (take) begin
				evaluate_symbol(s_axis_tdata, s_axis_tlast);
				chars_accepted++;
			end
			if (!s_axis_tvalid || take) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_chars.size() > 0) begin
					next_ch = pending_chars.pop_front();
					s_axis_tdata  <= next_ch.sym;
					s_axis_tlast  <= next_ch.last;
					s_axis_tvalid <= 1'b1;
					if (burst_left <= 1) begin
						// now and then a long back-to-back stretch
						if ($urandom_range(0, 7) == 0) begin
							burst_left = $urandom_range(100, 300);
							gap_left   = 0;
						end else begin
							burst_left = $urandom_range(1, 16);
							gap_left   = $urandom_range(0, 10);
						end
					end else begin
						burst_left--;
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- result monitor

	int stall_mode   = 0;
	int stall_timer  = 0;
	int stall_phase  = 0;

	always @(posedge clk) begin : result_monitor
		result_t exp_r;
		logic    ready_next;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result with none expected: value=%0d status=%0d",
						$signed(m_axis_tdata), m_axis_tuser));
				end else begin
					exp_r = expected_results.pop_front();
					if ($signed(m_axis_tdata) !== exp_r.value)
						report_mismatch($sformatf("result %0d value %0d, expected %0d",
							results_seen, $signed(m_axis_tdata), exp_r.value));
					if (m_axis_tuser !== exp_r.status)
						report_mismatch($sformatf("result %0d status %0d, expected %0d",
							results_seen, m_axis_tuser, exp_r.status));
				end
			end
			// receiver stall pattern switches mode every so often
			if (stall_timer == 0) begin
				stall_mode  = $urandom_range(0, 3);
				stall_timer = $urandom_range(20, 300);
			end else begin
				stall_timer--;
			end
			stall_phase++;
			case (stall_mode)
				0:       ready_next = 1'b1;
				1:       ready_next = $urandom_range(0, 1);
				2:       ready_next = ($urandom_range(0, 7) == 0);
				default: ready_next = (stall_phase % 5) >= 2;
			endcase
			m_axis_tready <= ready_next;
		end
	end

	// ---------------------------------------------------------------- watchdog

	int idle_cycles = 0;

	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", idle_cycles);
				$display("postfix_expression_evaluator test failed");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		foreach (status_tally[i])
			status_tally[i] = 0;
		clear_calculator();

		// Directed: plain digit, lone operator, 0/0 leaving the stack empty,
		// both subtraction orders, fractional divide, multiply, clipping chain,
		// ignored bytes with all bits set and all clear as the only character.
		queue_text("5");
		queue_text("+");
		queue_text("0/");
		queue_text("94-");
		queue_text("49-");
		queue_text("92/");
		queue_text("93*");
		queue_text("99*9*9*9*");
		queue_char(8'hFF, 1'b1);
		queue_char(8'h00, 1'b1);

		token_count = 0;
		while (token_count < RANDOM_TOKENS)
			queue_random_expression();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_chars.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d expressions from %0d characters, %0d results received.",
			expressions, chars_accepted, results_seen);
		$display("Status mix: ok %0d, divide by zero %0d, underflow %0d, overflow %0d, clipped %0d",
			status_tally[ST_OK], status_tally[ST_DIVZERO], status_tally[ST_UNDER],
			status_tally[ST_OVER], status_tally[ST_SAT]);
		if (error_count == 0) begin
			$display("postfix_expression_evaluator test passed");
		end else begin
			$display("postfix_expression_evaluator test failed");
		end
		$finish;
	end

endmodule

### sim.f
hw/rtl/pfe_pkg.sv
hw/rtl/postfix_expression_evaluator.sv
hw/rtl/pfe_checker.sv
test/postfix_expression_evaluator_tb.sv
